FILE: rtl/alu_barrel_shifter_flags_core_assert.svh
// Assertion macros for the checker file.
`ifndef ALU_BARREL_SHIFTER_FLAGS_CORE_ASSERT_SVH
`define ALU_BARREL_SHIFTER_FLAGS_CORE_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define ABSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ABSF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/absf_pkg.sv
package absf_pkg;

  // ALU opcodes, instruction bits 24:21
  typedef enum logic [3:0] {
    OP_AND = 4'h0,
    OP_EOR = 4'h1,
    OP_SUB = 4'h2,
    OP_RSB = 4'h3,
    OP_ADD = 4'h4,
    OP_ADC = 4'h5,
    OP_SBC = 4'h6,
    OP_RSC = 4'h7,
    OP_TST = 4'h8,
    OP_TEQ = 4'h9,
    OP_CMP = 4'hA,
    OP_CMN = 4'hB,
    OP_ORR = 4'hC,
    OP_MOV = 4'hD,
    OP_BIC = 4'hE,
    OP_MVN = 4'hF
  } alu_op_e;

  // Shift types, instruction bits 6:5
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_type_e;

  localparam logic [3:0]  PC_INDEX    = 4'hF;
  localparam logic [31:0] PC_OFFSET   = 32'd4;
  localparam logic [7:0]  WORD_BITS   = 8'd32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Decoded item handed from front to back
  typedef struct packed {
    alu_op_e     opcode;
    logic [31:0] op1;
    logic [31:0] op2;
    logic        shift_carry;
    logic [3:0]  dest;
    logic        negative;
    logic        zero;
    logic        carry;
    logic        overflow;
    logic        arith;
    logic        writes;
    logic        flag_update;
    logic        pc_written;
    logic        status_restore;
  } item_t;

  // Rotate right by 0..31
  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    rotr32 = (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

endpackage

FILE: rtl/absf_front.sv
module absf_front import absf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  input  logic [31:0] first_operand_value_i,
  input  logic [31:0] shifted_register_value_i,
  input  logic [31:0] shift_register_value_i,
  input  logic        negative_in_i,
  input  logic        zero_in_i,
  input  logic        carry_in_i,
  input  logic        overflow_in_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output item_t       push_item_o
);

  logic        vld_q, vld_d;
  item_t       item_q, item_d;

  logic        imm;
  logic        reg_shift;
  logic [4:0]  imm_amt;
  shift_type_e sh_type;
  alu_op_e     opc;
  logic [3:0]  rd;
  logic [31:0] op1;
  logic [31:0] rm;
  logic [7:0]  amt8;
  logic [7:0]  amt_eff;
  logic        big;
  logic [5:0]  amt6;
  logic [32:0] lsl_ext;
  logic [32:0] lsr_ext;
  logic signed [32:0] asr_ext;
  logic [31:0] op2;
  logic        shc;
  logic [31:0] imm_rot;
  logic        arith;
  logic        writes;

  // Field decode
  assign imm       = instruction_i[25];
  assign reg_shift = instruction_i[4];
  assign imm_amt   = instruction_i[11:7];
  assign sh_type   = shift_type_e'(instruction_i[6:5]);
  assign opc       = alu_op_e'(instruction_i[24:21]);
  assign rd        = instruction_i[15:12];

  // PC operands read 4 ahead with a register-specified shift
  always_comb begin
    op1 = first_operand_value_i;
    rm  = shifted_register_value_i;
    if (!imm && reg_shift) begin
      if (instruction_i[19:16] == PC_INDEX) op1 = first_operand_value_i + PC_OFFSET;
      if (instruction_i[3:0] == PC_INDEX)   rm  = shifted_register_value_i + PC_OFFSET;
    end
  end

  // Shift amount: immediate 0 means 32 for LSR/ASR
  assign amt8    = reg_shift ? shift_register_value_i[7:0] : {3'b000, imm_amt};
  assign amt_eff = (!reg_shift && imm_amt == 5'd0) ? WORD_BITS : amt8;
  assign big     = amt_eff > WORD_BITS;
  assign amt6    = big ? WORD_BITS[5:0] : amt_eff[5:0];
  assign lsl_ext = {1'b0, rm} << amt6;
  assign lsr_ext = {rm, 1'b0} >> amt6;
  assign asr_ext = $signed({rm, 1'b0}) >>> amt6;
  assign imm_rot = rotr32({24'd0, instruction_i[7:0]}, {instruction_i[11:8], 1'b0});

  // Operand 2 and shifter carry
  always_comb begin
    op2 = rm;
    shc = carry_in_i;
    if (imm) begin
      op2 = imm_rot;
      shc = (instruction_i[11:8] == 4'd0) ? carry_in_i : imm_rot[31];
    end else if ((reg_shift && amt8 == 8'd0) ||
                 (!reg_shift && imm_amt == 5'd0 && sh_type == SH_LSL)) begin
      op2 = rm;
      shc = carry_in_i;
    end else if (!reg_shift && imm_amt == 5'd0 && sh_type == SH_ROR) begin
      // RRX
      op2 = {carry_in_i, rm[31:1]};
      shc = rm[0];
    end else begin
      unique case (sh_type)
        SH_LSL: begin
          op2 = big ? 32'd0 : lsl_ext[31:0];
          shc = big ? 1'b0 : lsl_ext[32];
        end
        SH_LSR: begin
          op2 = big ? 32'd0 : lsr_ext[32:1];
          shc = big ? 1'b0 : lsr_ext[0];
        end
        SH_ASR: begin
          op2 = asr_ext[32:1];
          shc = asr_ext[0];
        end
        SH_ROR: begin
          op2 = rotr32(rm, amt_eff[4:0]);
          shc = op2[31];
        end
        default: begin
          op2 = rm;
          shc = carry_in_i;
        end
      endcase
    end
  end

  // Operation class
  always_comb begin
    arith = 1'b0;
    unique case (opc) inside
      OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC, OP_CMP, OP_CMN: arith = 1'b1;
      default: arith = 1'b0;
    endcase
  end

  always_comb begin
    writes = 1'b1;
    unique case (opc) inside
      OP_TST, OP_TEQ, OP_CMP, OP_CMN: writes = 1'b0;
      default: writes = 1'b1;
    endcase
  end

  // Build the decoded item
  always_comb begin
    item_d.opcode         = opc;
    item_d.op1            = op1;
    item_d.op2            = op2;
    item_d.shift_carry    = shc;
    item_d.dest           = rd;
    item_d.negative       = negative_in_i;
    item_d.zero           = zero_in_i;
    item_d.carry          = carry_in_i;
    item_d.overflow       = overflow_in_i;
    item_d.arith          = arith;
    item_d.writes         = writes;
    item_d.flag_update    = instruction_i[20] && (rd != PC_INDEX);
    item_d.pc_written     = writes && (rd == PC_INDEX);
    item_d.status_restore = instruction_i[20] && (rd == PC_INDEX);
  end

  // Front register
  assign in_ready_o   = !vld_q || push_ready_i;
  assign push_valid_o = vld_q;
  assign push_item_o  = item_q;
  assign vld_d        = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: rtl/absf_queue.sv
module absf_queue import absf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             entries_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop)      cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/absf_back.sv
module absf_back import absf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  item_t       pop_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_value_o,
  output logic        write_result_o,
  output logic [3:0]  dest_index_o,
  output logic        negative_out_o,
  output logic        zero_out_o,
  output logic        carry_out_o,
  output logic        overflow_out_o,
  output logic        pc_written_o,
  output logic        status_restore_o
);

  typedef struct packed {
    logic [31:0] value;
    logic        write;
    logic [3:0]  dest;
    logic        negative;
    logic        zero;
    logic        carry;
    logic        overflow;
    logic        pc_written;
    logic        status_restore;
  } result_t;

  logic        vld_q, vld_d;
  result_t     res_q, res_d;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_cin;
  logic [32:0] sum;
  logic        add_v;
  logic [31:0] res;
  logic        pop;

  // Adder operand select
  always_comb begin
    add_a   = pop_item_i.op1;
    add_b   = pop_item_i.op2;
    add_cin = 1'b0;
    unique case (pop_item_i.opcode) inside
      OP_SUB, OP_CMP: begin
        add_b   = ~pop_item_i.op2;
        add_cin = 1'b1;
      end
      OP_RSB: begin
        add_a   = pop_item_i.op2;
        add_b   = ~pop_item_i.op1;
        add_cin = 1'b1;
      end
      OP_ADC: add_cin = pop_item_i.carry;
      OP_SBC: begin
        add_b   = ~pop_item_i.op2;
        add_cin = pop_item_i.carry;
      end
      OP_RSC: begin
        add_a   = pop_item_i.op2;
        add_b   = ~pop_item_i.op1;
        add_cin = pop_item_i.carry;
      end
      default: add_cin = 1'b0;
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
  assign add_v = (add_a[31] == add_b[31]) && (sum[31] != add_a[31]);

  // Result select
  always_comb begin
    unique case (pop_item_i.opcode) inside
      OP_AND, OP_TST: res = pop_item_i.op1 & pop_item_i.op2;
      OP_EOR, OP_TEQ: res = pop_item_i.op1 ^ pop_item_i.op2;
      OP_ORR:         res = pop_item_i.op1 | pop_item_i.op2;
      OP_MOV:         res = pop_item_i.op2;
      OP_BIC:         res = pop_item_i.op1 & ~pop_item_i.op2;
      OP_MVN:         res = ~pop_item_i.op2;
      default:        res = sum[31:0];
    endcase
  end

  // Flags and result word
  always_comb begin
    res_d.value          = res;
    res_d.write          = pop_item_i.writes;
    res_d.dest           = pop_item_i.dest;
    res_d.pc_written     = pop_item_i.pc_written;
    res_d.status_restore = pop_item_i.status_restore;
    if (pop_item_i.flag_update) begin
      res_d.negative = res[31];
      res_d.zero     = res == 32'd0;
      res_d.carry    = pop_item_i.arith ? sum[32] : pop_item_i.shift_carry;
      res_d.overflow = pop_item_i.arith ? add_v : pop_item_i.overflow;
    end else begin
      res_d.negative = pop_item_i.negative;
      res_d.zero     = pop_item_i.zero;
      res_d.carry    = pop_item_i.carry;
      res_d.overflow = pop_item_i.overflow;
    end
  end

  // Output register
  assign pop_ready_o = !vld_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign vld_d       = pop_ready_o ? pop_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = vld_q;
  assign result_value_o   = res_q.value;
  assign write_result_o   = res_q.write;
  assign dest_index_o     = res_q.dest;
  assign negative_out_o   = res_q.negative;
  assign zero_out_o       = res_q.zero;
  assign carry_out_o      = res_q.carry;
  assign overflow_out_o   = res_q.overflow;
  assign pc_written_o     = res_q.pc_written;
  assign status_restore_o = res_q.status_restore;

endmodule

FILE: rtl/alu_barrel_shifter_flags_core.sv
// Data-processing execute unit: one instruction word plus operand values and
// N/Z/C/V flags in, one result item out (result, write enable, destination,
// new flags, PC-written and status-restore). It takes one item every cycle
// while the output side keeps up. The path runs through a front register after
// decode, PC adjust and the barrel shifter; a QUEUE_DEPTH-entry queue; and the
// output register after the adder and flag logic. The front and back each
// stall on their own; when the output stalls, the queue absorbs up to
// QUEUE_DEPTH items plus one in the front register before in_ready_o drops.
module alu_barrel_shifter_flags_core import absf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  input  logic [31:0] first_operand_value_i,
  input  logic [31:0] shifted_register_value_i,
  input  logic [31:0] shift_register_value_i,
  input  logic        negative_in_i,
  input  logic        zero_in_i,
  input  logic        carry_in_i,
  input  logic        overflow_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_value_o,
  output logic        write_result_o,
  output logic [3:0]  dest_index_o,
  output logic        negative_out_o,
  output logic        zero_out_o,
  output logic        carry_out_o,
  output logic        overflow_out_o,
  output logic        pc_written_o,
  output logic        status_restore_o
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // Decode and operand 2
  absf_front u_front (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .instruction_i            (instruction_i),
    .first_operand_value_i    (first_operand_value_i),
    .shifted_register_value_i (shifted_register_value_i),
    .shift_register_value_i   (shift_register_value_i),
    .negative_in_i            (negative_in_i),
    .zero_in_i                (zero_in_i),
    .carry_in_i               (carry_in_i),
    .overflow_in_i            (overflow_in_i),
    .push_valid_o             (push_valid),
    .push_ready_i             (push_ready),
    .push_item_o              (push_item)
  );

  // Decoupling queue
  absf_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // ALU and flags
  absf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_item_i       (pop_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_value_o   (result_value_o),
    .write_result_o   (write_result_o),
    .dest_index_o     (dest_index_o),
    .negative_out_o   (negative_out_o),
    .zero_out_o       (zero_out_o),
    .carry_out_o      (carry_out_o),
    .overflow_out_o   (overflow_out_o),
    .pc_written_o     (pc_written_o),
    .status_restore_o (status_restore_o)
  );

endmodule

FILE: rtl/absf_checker.sv
`include "alu_barrel_shifter_flags_core_assert.svh"

module absf_checker import absf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       write_result_i,
  input logic [3:0] dest_index_i,
  input logic       pc_written_i,
  input logic       status_restore_i
);

  // No result shown while in reset
  `ABSF_ASSERT_RST(a_no_out_in_reset, !rst_ni |-> !out_valid_i, "out valid during reset")

  // A stalled result stays offered
  `ABSF_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")

  // PC write only for a writing op to register 15
  `ABSF_ASSERT(a_pc_written, out_valid_i && pc_written_i |-> write_result_i && (dest_index_i == PC_INDEX), "bad pc_written")

  // Status restore only with destination 15
  `ABSF_ASSERT(a_restore_dest, out_valid_i && status_restore_i |-> dest_index_i == PC_INDEX, "bad restore")

endmodule

bind alu_barrel_shifter_flags_core absf_checker u_absf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .write_result_i   (write_result_o),
  .dest_index_i     (dest_index_o),
  .pc_written_i     (pc_written_o),
  .status_restore_i (status_restore_o)
);
